// File: design/rrtl_pkg.sv
// ---------------------------------------------------------------------------
// rrtl_pkg: shared types and constants for the round-robin target latch
// Operation codes, payload structs and the control/status bundles that
// pass between the controller and the datapath.
// ---------------------------------------------------------------------------
package rrtl_pkg;

	// Default valve count and fixed field widths
	localparam int VALVE_COUNT_DEF = 12;
	localparam int IDX_W           = 4;
	localparam int POS_W           = 8;
	localparam int SLOTS           = 1 << IDX_W;

	// Operation codes
	typedef enum logic [1:0] {
		FUNC_SET   = 2'd0,
		FUNC_CLEAR = 2'd1,
		FUNC_FIND  = 2'd2,
		FUNC_QUERY = 2'd3
	} func_t;

	// Input item
	typedef struct packed {
		func_t              func;
		logic [IDX_W-1:0]   valve_index;
		logic [POS_W-1:0]   position;
		logic [IDX_W-1:0]   start_index;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic               found;
		logic [IDX_W-1:0]   found_valve;
		logic [POS_W-1:0]   found_position;
		logic               is_pending;
	} out_item_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;   // latch the accepted item, seed the scan
		logic apply;     // perform set or clear
		logic step;      // advance the scan pointer
		logic hit_take;  // record a hit and read the stored position
		logic miss_take; // record that the scan found nothing
		logic load;      // load the result register
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_find;
		logic hit;
		logic last;
		logic out_free;
	} stat_t;

endpackage

// File: design/rrtl_ctrl.sv
// ---------------------------------------------------------------------------
// rrtl_ctrl: sequencing state machine
// Accepts one item at a time, runs the one-valve-per-cycle scan for find
// items and hands the result to the output register when it is free.
// ---------------------------------------------------------------------------
module rrtl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  rrtl_pkg::stat_t stat,
	output rrtl_pkg::cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   in_xfer;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && (state_q == ST_IDLE);

	// Command decode
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: cmd.capture = in_xfer;
			ST_EXEC: cmd.apply   = !stat.is_find;
			ST_SCAN: begin
				if (stat.hit) begin
					cmd.hit_take = 1'b1;
				end else if (stat.last) begin
					cmd.miss_take = 1'b1;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_EMIT: cmd.load = stat.out_free;
			default: cmd = '0;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_xfer) state_q <= ST_EXEC;
				ST_EXEC: state_q <= stat.is_find ? ST_SCAN : ST_EMIT;
				ST_SCAN: if (stat.hit || stat.last) state_q <= ST_EMIT;
				ST_EMIT: if (stat.out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: design/rrtl_dpath.sv
// ---------------------------------------------------------------------------
// rrtl_dpath: pending mask, position store, scan pointer and result register
// Executes the commands of the controller and reports scan status back.
// ---------------------------------------------------------------------------
module rrtl_dpath #(
	parameter int VALVE_COUNT = rrtl_pkg::VALVE_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rrtl_pkg::in_item_t  in_data,
	input  rrtl_pkg::cmd_t      cmd,
	output rrtl_pkg::stat_t     stat,
	output logic                out_valid,
	input  logic                out_stall,
	output rrtl_pkg::out_item_t out_data
);

	localparam int IDX_W = rrtl_pkg::IDX_W;
	localparam int POS_W = rrtl_pkg::POS_W;
	localparam int SLOTS = rrtl_pkg::SLOTS;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VALVE_COUNT - 1);

	// Start index reduced modulo the valve count, one constant per code
	logic [IDX_W-1:0] base_lut [SLOTS];
	for (genvar i = 0; i < SLOTS; i++) begin : g_base
		localparam logic [IDX_W-1:0] BASE = IDX_W'(i % VALVE_COUNT);
		assign base_lut[i] = BASE;
	end

	rrtl_pkg::func_t   func_q;
	logic [IDX_W-1:0]  valve_q;
	logic [POS_W-1:0]  pos_q;
	logic [IDX_W-1:0]  cur_q;
	logic [IDX_W-1:0]  steps_q;
	logic              hit_q;
	logic [POS_W-1:0]  rd_q;
	logic [SLOTS-1:0]  mask_q;
	logic [POS_W-1:0]  store [SLOTS];
	logic              out_valid_q;
	rrtl_pkg::out_item_t out_q;
	rrtl_pkg::out_item_t res;
	logic              in_range;
	logic              found;

	assign in_range = {1'b0, valve_q} < (IDX_W+1)'(VALVE_COUNT);

	// Status to the controller
	assign stat.is_find  = (func_q == rrtl_pkg::FUNC_FIND);
	assign stat.hit      = mask_q[cur_q];
	assign stat.last     = (steps_q == LAST_IDX);
	assign stat.out_free = !out_valid_q || !out_stall;

	// Item capture and scan pointer
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q  <= in_data.func;
			valve_q <= in_data.valve_index;
			pos_q   <= in_data.position;
			cur_q   <= base_lut[in_data.start_index];
			steps_q <= '0;
		end else if (cmd.step) begin
			cur_q   <= (cur_q == LAST_IDX) ? '0 : cur_q + 1'b1;
			steps_q <= steps_q + 1'b1;
		end
		if (cmd.hit_take) begin
			hit_q <= 1'b1;
		end else if (cmd.miss_take) begin
			hit_q <= 1'b0;
		end
	end

	// Pending mask, changed only by set and clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (cmd.apply && in_range && (func_q == rrtl_pkg::FUNC_SET
			|| func_q == rrtl_pkg::FUNC_CLEAR)) begin
			mask_q[valve_q] <= (func_q == rrtl_pkg::FUNC_SET);
		end
	end

	// Position store, registered read at the scan pointer
	always_ff @(posedge clk) begin
		if (cmd.apply && in_range && func_q == rrtl_pkg::FUNC_SET) begin
			store[valve_q] <= pos_q;
		end
		if (cmd.hit_take) begin
			rd_q <= store[cur_q];
		end
	end

	// Result assembly
	assign found              = (func_q == rrtl_pkg::FUNC_FIND) && hit_q;
	assign res.found          = found;
	assign res.found_valve    = found ? cur_q : '0;
	assign res.found_position = found ? rd_q : '0;
	assign res.is_pending     = (func_q == rrtl_pkg::FUNC_QUERY) && in_range
		&& mask_q[valve_q];

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: design/round_robin_target_latch_core.sv
// ---------------------------------------------------------------------------
// round_robin_target_latch_core: pending target latch with round-robin find
// Keeps a pending mark and a target position per valve. Set, clear, find
// and query items each yield one result item.
//
// Channels: in_valid/in_stall/in_data take items, out_valid/out_stall/
// out_data deliver results; a transfer happens when valid is high and stall
// is low. One item is in work at a time; in_stall is high while it is.
// From an input transfer, set, clear and query pass through the execute
// and emit states to out_valid; a find passes through execute, then the
// scan, which checks one valve per cycle from the start index until it
// hits a pending valve or has looked at all of them, then emit. The next
// item is accepted in the cycle after the result is loaded, never before.
// The result sits in an output register: a new item is accepted while it
// waits, and while it holds a result that out_stall keeps, a finished
// item waits before loading.
// Reset clears the pending mask and the output register; stored positions
// are not cleared and are read only after a set has written them.
// ---------------------------------------------------------------------------
module round_robin_target_latch_core #(
	parameter int VALVE_COUNT = rrtl_pkg::VALVE_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  rrtl_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output rrtl_pkg::out_item_t out_data
);

	rrtl_pkg::cmd_t  cmd;
	rrtl_pkg::stat_t stat;

	// Controller
	rrtl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath
	rrtl_dpath #(
		.VALVE_COUNT (VALVE_COUNT)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// File: verif/rrtl_result_checker.sv
// ---------------------------------------------------------------------------
// rrtl_result_checker: scoreboard for the round-robin target latch
// Watches both channels. Each input transfer is run through a local copy of
// the pending mask and the position store, and the answer goes into a queue.
// Each output transfer is compared field by field with the oldest answer.
// ---------------------------------------------------------------------------
module rrtl_result_checker #(
	parameter int VALVE_COUNT = rrtl_pkg::VALVE_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  rrtl_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  rrtl_pkg::out_item_t out_data,
	output int                  fail_count,
	output int                  outstanding
);

	// Local copy of the latch state
	logic [rrtl_pkg::SLOTS-1:0] pending_valves = '0;
	logic [rrtl_pkg::POS_W-1:0] target_pos [rrtl_pkg::SLOTS];

	rrtl_pkg::out_item_t answer_q [$];
	int                  errors = 0;

	// Apply one command to the local state and return the answer it owes
	function automatic rrtl_pkg::out_item_t latch_apply(input rrtl_pkg::in_item_t cmd);
		rrtl_pkg::out_item_t ans;
		int unsigned         base;
		int unsigned         v;
		ans = '0;
		case (cmd.func)
			rrtl_pkg::FUNC_SET: begin
				if (cmd.valve_index < VALVE_COUNT) begin
					pending_valves[cmd.valve_index] = 1'b1;
					target_pos[cmd.valve_index]     = cmd.position;
				end
			end
			rrtl_pkg::FUNC_CLEAR: begin
				// stored position is kept
				if (cmd.valve_index < VALVE_COUNT)
					pending_valves[cmd.valve_index] = 1'b0;
			end
			rrtl_pkg::FUNC_FIND: begin
				base = cmd.start_index % VALVE_COUNT;
				for (int k = 0; k < VALVE_COUNT; k++) begin
					v = (base + k) % VALVE_COUNT;
					if (!ans.found && pending_valves[v]) begin
						ans.found          = 1'b1;
						ans.found_valve    = v[rrtl_pkg::IDX_W-1:0];
						ans.found_position = target_pos[v];
					end
				end
			end
			default: begin
				ans.is_pending = (cmd.valve_index < VALVE_COUNT) &&
					pending_valves[cmd.valve_index];
			end
		endcase
		return ans;
	endfunction

	task automatic check_field(input string name, input logic [7:0] exp_v,
		input logic [7:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
				exp_v, got_v);
			errors++;
		end
	endtask

	// Sample both channels at the clock edge
	always @(posedge clk) begin
		rrtl_pkg::out_item_t exp_r;
		if (arst_n) begin
			if (in_valid && !in_stall)
				answer_q.push_back(latch_apply(in_data));
			if (out_valid && !out_stall) begin
				if (answer_q.size() == 0) begin
					$display("%0t: result transfer with nothing expected, actual %p",
						$time, out_data);
					errors++;
				end else begin
					exp_r = answer_q.pop_front();
					check_field("found", 8'(exp_r.found), 8'(out_data.found));
					check_field("found_valve", 8'(exp_r.found_valve),
						8'(out_data.found_valve));
					check_field("found_position", exp_r.found_position,
						out_data.found_position);
					check_field("is_pending", 8'(exp_r.is_pending),
						8'(out_data.is_pending));
				end
			end
		end
		fail_count  <= errors;
		outstanding <= answer_q.size();
	end

endmodule

// File: verif/testbench.sv
// ---------------------------------------------------------------------------
// testbench: stimulus and verdict for round_robin_target_latch_core
// Drives a directed run over the valve range edges, wrap-around finds and
// ignored set/clear, then random commands with idle and stall bursts.
// The checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module testbench;

	localparam int VC         = rrtl_pkg::VALVE_COUNT_DEF;
	localparam int RAND_ITEMS = 450;
	localparam int CALM_ITEMS = 60;
	localparam int IDLE_LIMIT = 2000;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	rrtl_pkg::in_item_t  in_data;
	logic                out_valid;
	logic                out_stall;
	rrtl_pkg::out_item_t out_data;
	int                  fail_count;
	int                  outstanding;
	bit                  calm = 1'b0;
	int                  idle_cycles = 0;

	round_robin_target_latch_core #(.VALVE_COUNT(VC)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	rrtl_result_checker #(.VALVE_COUNT(VC)) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Send one command, with an occasional idle burst ahead of it
	task automatic send_cmd(input rrtl_pkg::func_t f, input int valve, input int pos,
		input int start);
		rrtl_pkg::in_item_t cmd;
		cmd.func        = f;
		cmd.valve_index = valve[rrtl_pkg::IDX_W-1:0];
		cmd.position    = pos[rrtl_pkg::POS_W-1:0];
		cmd.start_index = start[rrtl_pkg::IDX_W-1:0];
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= cmd;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Receiver stall bursts
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			out_stall <= 1'b0;
			// stretch with no stall at all
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(10, 40)) @(posedge clk);
		end
	end

	// Watchdog: cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		int              sel;
		int              valve;
		rrtl_pkg::func_t f;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty latch, range edges, ignored writes, wrap-around
		send_cmd(rrtl_pkg::FUNC_QUERY, 0, 0, 0);
		send_cmd(rrtl_pkg::FUNC_FIND, 0, 0, 0);
		send_cmd(rrtl_pkg::FUNC_SET, 0, 8'h00, 0);
		send_cmd(rrtl_pkg::FUNC_SET, VC - 1, 8'hff, 15);
		send_cmd(rrtl_pkg::FUNC_SET, VC, 8'haa, 0);
		send_cmd(rrtl_pkg::FUNC_SET, 15, 8'h55, 0);
		send_cmd(rrtl_pkg::FUNC_FIND, 0, 0, 0);
		send_cmd(rrtl_pkg::FUNC_FIND, 0, 0, 1);
		send_cmd(rrtl_pkg::FUNC_FIND, 0, 0, VC);
		send_cmd(rrtl_pkg::FUNC_FIND, 15, 8'hff, 15);
		send_cmd(rrtl_pkg::FUNC_QUERY, VC - 1, 0, 0);
		send_cmd(rrtl_pkg::FUNC_QUERY, VC, 0, 0);
		send_cmd(rrtl_pkg::FUNC_QUERY, 15, 0, 0);
		send_cmd(rrtl_pkg::FUNC_CLEAR, 0, 0, 0);
		send_cmd(rrtl_pkg::FUNC_CLEAR, 13, 0, 0);
		send_cmd(rrtl_pkg::FUNC_FIND, 0, 0, 5);
		send_cmd(rrtl_pkg::FUNC_CLEAR, VC - 1, 0, 0);
		send_cmd(rrtl_pkg::FUNC_FIND, 0, 0, 7);
		send_cmd(rrtl_pkg::FUNC_QUERY, 0, 0, 0);
		send_cmd(rrtl_pkg::FUNC_SET, 6, 8'h5a, 0);
		send_cmd(rrtl_pkg::FUNC_SET, 6, 8'ha5, 0);
		send_cmd(rrtl_pkg::FUNC_FIND, 0, 0, VC - 1);
		send_cmd(rrtl_pkg::FUNC_CLEAR, 6, 0, 0);
		send_cmd(rrtl_pkg::FUNC_SET, 6, 8'h00, 0);
		send_cmd(rrtl_pkg::FUNC_FIND, 0, 0, 6);

		// Random commands, mostly in range
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n == RAND_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			sel = $urandom_range(0, 99);
			if (sel < 35)
				f = rrtl_pkg::FUNC_SET;
			else if (sel < 55)
				f = rrtl_pkg::FUNC_CLEAR;
			else if (sel < 85)
				f = rrtl_pkg::FUNC_FIND;
			else
				f = rrtl_pkg::FUNC_QUERY;
			if (VC < rrtl_pkg::SLOTS && $urandom_range(0, 9) == 0)
				valve = $urandom_range(VC, rrtl_pkg::SLOTS - 1);
			else
				valve = $urandom_range(0, VC - 1);
			send_cmd(f, valve, $urandom_range(0, 255), $urandom_range(0, 15));
		end
		in_valid <= 1'b0;

		// Drain, then allow a full scan worth of cycles
		while (outstanding != 0) @(posedge clk);
		repeat (VC + 8) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
